[design/slcan_pkg.sv]
// Shared types, character codes and reply codes for the ASCII CAN command parser.
// Used by slcan_ctrl, slcan_dp and slcan_command_parser_core; no dependencies.

package slcan_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_OPEN  = 8'h4F; // 'O'
    localparam logic [7:0] CH_CLOSE = 8'h43; // 'C'
    localparam logic [7:0] CH_SPEED = 8'h53; // 'S'
    localparam logic [7:0] CH_VER   = 8'h56; // 'V'
    localparam logic [7:0] CH_SER   = 8'h4E; // 'N'
    localparam logic [7:0] CH_STD   = 8'h74; // 't'
    localparam logic [7:0] CH_EXT   = 8'h54; // 'T'

    localparam logic [2:0] REPLY_OK      = 3'd0;
    localparam logic [2:0] REPLY_BELL    = 3'd1;
    localparam logic [2:0] REPLY_VERSION = 3'd2;
    localparam logic [2:0] REPLY_SERIAL  = 3'd3;
    localparam logic [2:0] REPLY_ACK_STD = 3'd4;
    localparam logic [2:0] REPLY_ACK_EXT = 3'd5;

    localparam logic [3:0] MAX_DLC = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;      // store a character of the line
        logic start;   // line end seen: clear decode state, latch link flag
        logic step;    // read the next stored character
        logic finish;  // load the result register and empty the line
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic eol;       // current input byte ends a line
        logic empty;     // no characters held
        logic last;      // read pointer is at the final stored character
        logic out_free;  // result register can take a new beat
    } t_dp_status;

    // Hex digit decode: bit 4 set when the character is a valid digit.
    function automatic logic [4:0] digit_value(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            res = {1'b1, 4'(ch - 8'h30)};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            res = {1'b1, 4'(ch - 8'h57)};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            res = {1'b1, 4'(ch - 8'h37)};
        end
        return res;
    endfunction

endpackage

[design/slcan_ctrl.sv]
// Controller state machine of the command parser: accepts bytes and sequences
// the walk over the stored line. Depends on slcan_pkg.

module slcan_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  slcan_pkg::t_dp_status  i_status,
    output slcan_pkg::t_ctrl_cmd   o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.wr    = accept && !i_status.eol;
                o_cmd.start = accept && i_status.eol && !i_status.empty;
                if (o_cmd.start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                if (i_status.last) begin
                    n_state = ST_DRAIN;
                end
            end
            // The last read returns here and is decoded at the end of this cycle.
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.finish = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_finish_needs_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_status.out_free)
        else $error("result loaded while the output register is occupied");

    a_start_walks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_WALK) && o_cmd.step)
        else $error("line end did not begin the walk");

    a_no_write_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd.wr && !o_cmd.start)
        else $error("character taken while a line is being decoded");

    a_walk_ends_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) && i_status.last |=> (r_state == ST_DRAIN) && !o_cmd.step)
        else $error("walk overran the stored line");
`endif

endmodule

[design/slcan_dp.sv]
// Datapath of the command parser: line store, character decode registers,
// channel flag and the result register. Depends on slcan_pkg.

module slcan_dp #(
    parameter int LINE_SLOTS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  slcan_pkg::t_ctrl_cmd   i_cmd,
    output slcan_pkg::t_dp_status  o_status,
    input  logic [7:0]             i_rx_byte,
    input  logic                   i_link_ok,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [2:0]             o_reply_kind,
    output logic                   o_channel_is_open,
    output logic                   o_tx_valid,
    output logic                   o_tx_extended,
    output logic [28:0]            o_tx_ident,
    output logic [3:0]             o_tx_length,
    output logic [63:0]            o_tx_payload
);

    localparam int DEPTH = LINE_SLOTS - 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(LINE_SLOTS);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_rd_pos;
    logic          r_proc;
    logic          r_open;
    logic          r_link;
    logic [7:0]    r_cmd;
    logic          r_ext;
    logic          r_err;
    logic [28:0]   r_ident;
    logic [3:0]    r_dlc;
    logic [63:0]   r_payload;

    logic          r_out_valid;
    logic [2:0]    r_reply;
    logic          r_out_open;
    logic          r_txv;
    logic          r_txe;
    logic [28:0]   r_tx_ident;
    logic [3:0]    r_tx_len;
    logic [63:0]   r_tx_payload;

    logic          full;
    logic [4:0]    dv;
    logic [7:0]    pos8;
    logic [7:0]    ndig8;
    logic [7:0]    base8;
    logic [7:0]    data_end8;
    logic [7:0]    count8;
    logic [3:0]    nib_idx;
    logic [5:0]    nib_off;
    logic          is_frame;
    logic          frame_ok;
    logic [2:0]    n_reply;
    logic          n_open;

    assign full = (r_count == CW'(DEPTH));

    assign o_status.eol      = (i_rx_byte == slcan_pkg::CH_CR) ||
                               (i_rx_byte == slcan_pkg::CH_LF);
    assign o_status.empty    = (r_count == '0);
    assign o_status.last     = (r_pos == r_count - CW'(1));
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // Line store: written while characters arrive, read one entry a cycle
    // during the walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && !full) begin
            mem[r_count[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.step) begin
            r_rd_data <= mem[r_pos[AW-1:0]];
        end
    end

    always_comb begin
        dv        = slcan_pkg::digit_value(r_rd_data);
        pos8      = 8'(r_rd_pos);
        ndig8     = r_ext ? 8'd8 : 8'd3;
        base8     = ndig8 + 8'd2;
        data_end8 = base8 + {3'b000, r_dlc, 1'b0};
        count8    = 8'(r_count);
        nib_idx   = 4'(pos8 - base8);
        // Byte i sits at bits 8i+7..8i; the first digit of a pair is the high nibble.
        nib_off   = {nib_idx[3:1], ~nib_idx[0], 2'b00};
    end

    always_comb begin
        is_frame = (r_cmd == slcan_pkg::CH_STD) || (r_cmd == slcan_pkg::CH_EXT);
        frame_ok = is_frame && !r_err && r_open &&
                   (count8 >= base8) && (count8 >= data_end8);
        n_open   = r_open;
        unique case (r_cmd)
            slcan_pkg::CH_OPEN: begin
                if (r_open) begin
                    n_reply = slcan_pkg::REPLY_OK;
                end else if (r_link) begin
                    n_reply = slcan_pkg::REPLY_OK;
                    n_open  = 1'b1;
                end else begin
                    n_reply = slcan_pkg::REPLY_BELL;
                end
            end
            slcan_pkg::CH_CLOSE: begin
                n_reply = slcan_pkg::REPLY_OK;
                n_open  = 1'b0;
            end
            slcan_pkg::CH_SPEED: n_reply = slcan_pkg::REPLY_OK;
            slcan_pkg::CH_VER:   n_reply = slcan_pkg::REPLY_VERSION;
            slcan_pkg::CH_SER:   n_reply = slcan_pkg::REPLY_SERIAL;
            slcan_pkg::CH_STD, slcan_pkg::CH_EXT: begin
                if (frame_ok && r_link) begin
                    n_reply = r_ext ? slcan_pkg::REPLY_ACK_EXT : slcan_pkg::REPLY_ACK_STD;
                end else begin
                    n_reply = slcan_pkg::REPLY_BELL;
                end
            end
            default: n_reply = slcan_pkg::REPLY_BELL;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_open      <= 1'b0;
            r_proc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_proc <= i_cmd.step;
            if (i_cmd.finish) begin
                r_count     <= '0;
                r_open      <= n_open;
                r_out_valid <= 1'b1;
            end else begin
                if (i_cmd.wr && !full) begin
                    r_count <= r_count + CW'(1);
                end
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // Decode registers, filled as the stored characters come back in order.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos     <= '0;
            r_link    <= i_link_ok;
            r_err     <= 1'b0;
            r_ident   <= '0;
            r_dlc     <= '0;
            r_payload <= '0;
        end else begin
            if (i_cmd.step) begin
                r_pos    <= r_pos + CW'(1);
                r_rd_pos <= r_pos;
            end
            if (r_proc) begin
                if (pos8 == 8'd0) begin
                    r_cmd <= r_rd_data;
                    r_ext <= (r_rd_data == slcan_pkg::CH_EXT);
                end else if (pos8 <= ndig8) begin
                    r_ident <= {r_ident[24:0], dv[3:0]};
                    if (!dv[4]) begin
                        r_err <= 1'b1;
                    end
                end else if (pos8 == ndig8 + 8'd1) begin
                    r_dlc <= dv[3:0];
                    if (!dv[4] || (dv[3:0] > slcan_pkg::MAX_DLC)) begin
                        r_err <= 1'b1;
                    end
                end else if (pos8 < data_end8) begin
                    r_payload[nib_off +: 4] <= dv[3:0];
                    if (!dv[4]) begin
                        r_err <= 1'b1;
                    end
                end
            end
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_reply      <= n_reply;
            r_out_open   <= n_open;
            r_txv        <= frame_ok;
            r_txe        <= frame_ok && r_ext;
            r_tx_ident   <= frame_ok ? r_ident : '0;
            r_tx_len     <= frame_ok ? r_dlc : '0;
            r_tx_payload <= frame_ok ? r_payload : '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_reply_kind      = r_reply;
    assign o_channel_is_open = r_out_open;
    assign o_tx_valid        = r_txv;
    assign o_tx_extended     = r_txe;
    assign o_tx_ident        = r_tx_ident;
    assign o_tx_length       = r_tx_len;
    assign o_tx_payload      = r_tx_payload;

endmodule

[design/slcan_command_parser_core.sv]
// Top level of the ASCII CAN command parser: joins the controller and the datapath.
// Depends on slcan_pkg, slcan_ctrl and slcan_dp.
//
//   channel | direction | handshake              | fields
//   --------+-----------+------------------------+------------------------------------------
//   in      | host in   | i_in_valid/o_in_stall  | rx_byte, link_ok
//   out     | reply out | o_out_valid/i_out_stall| reply_kind, channel_is_open, tx_* fields
//
// A character that does not end a line, or an empty line end, is taken without leaving idle.
// A line end that follows stored characters is taken, then the line store is read entry by entry
// (one port, one entry a cycle), the last character is decoded and the result register is
// loaded; the input is stalled during the reads, the decode and the load.
// The load waits while a previous reply is still stalled, which stretches the input stall.
// Reset clears the line count, the channel flag and the result valid; the store
// needs no clearing because only entries below the count are read.

module slcan_command_parser_core #(
    parameter int LINE_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_link_ok,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_reply_kind,
    output logic        o_channel_is_open,
    output logic        o_tx_valid,
    output logic        o_tx_extended,
    output logic [28:0] o_tx_ident,
    output logic [3:0]  o_tx_length,
    output logic [63:0] o_tx_payload
);

    slcan_pkg::t_ctrl_cmd  cmd;
    slcan_pkg::t_dp_status status;

    slcan_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    slcan_dp #(
        .LINE_SLOTS (LINE_SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_rx_byte         (i_rx_byte),
        .i_link_ok         (i_link_ok),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_reply_kind      (o_reply_kind),
        .o_channel_is_open (o_channel_is_open),
        .o_tx_valid        (o_tx_valid),
        .o_tx_extended     (o_tx_extended),
        .o_tx_ident        (o_tx_ident),
        .o_tx_length       (o_tx_length),
        .o_tx_payload      (o_tx_payload)
    );

endmodule

[dv/slcan_command_parser_core_tb.sv]
// Self-checking testbench for slcan_command_parser_core: drives host characters, predicts each
// reply from its own line model and compares every reply beat field by field.
// Depends on slcan_pkg and the RTL of slcan_command_parser_core.

module slcan_command_parser_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_SLOTS   = 32;
    localparam int LINE_CHARS   = LINE_SLOTS - 1;
    localparam int TOTAL_ITEMS  = 600;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [2:0]  kind;
        logic        is_open;
        logic        tx_valid;
        logic        tx_ext;
        logic [28:0] ident;
        logic [3:0]  dlc;
        logic [63:0] payload;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_link_ok = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_reply_kind;
    logic        o_channel_is_open;
    logic        o_tx_valid;
    logic        o_tx_extended;
    logic [28:0] o_tx_ident;
    logic [3:0]  o_tx_length;
    logic [63:0] o_tx_payload;

    // Line model of the parser.
    logic [7:0]  line_buf [LINE_CHARS];
    int          line_len = 0;
    bit          chan_open = 1'b0;

    t_reply      expected_replies [$];
    t_reply      oldest_reply;
    logic [7:0]  line_chars [$];
    int          fail_count = 0;
    int          sent_count = 0;
    int          burst_left = 0;
    bit          sender_eager = 1'b0;
    int unsigned stall_phase = 0;
    int          stall_style = 0;

    slcan_command_parser_core #(
        .LINE_SLOTS(LINE_SLOTS)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .i_link_ok         (i_link_ok),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_reply_kind      (o_reply_kind),
        .o_channel_is_open (o_channel_is_open),
        .o_tx_valid        (o_tx_valid),
        .o_tx_extended     (o_tx_extended),
        .o_tx_ident        (o_tx_ident),
        .o_tx_length       (o_tx_length),
        .o_tx_payload      (o_tx_payload)
    );

    always #6 i_clk = ~i_clk;

    function automatic int hex_val(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
        if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
        if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] char_at(input int pos);
        if (pos >= line_len) return 8'h00;
        return line_buf[pos];
    endfunction

    function automatic bit decode_frame(input bit ext, output logic [28:0] id,
                                        output logic [3:0] dlc, output logic [63:0] data);
        int          ndig;
        int          base;
        int          v;
        int          hi;
        int          lo;
        logic [31:0] acc;
        ndig = ext ? 8 : 3;
        base = ndig + 2;
        acc  = '0;
        id   = '0;
        dlc  = '0;
        data = '0;
        if (!chan_open || line_len < base) return 1'b0;
        for (int i = 1; i <= ndig; i++) begin
            v = hex_val(char_at(i));
            if (v < 0) return 1'b0;
            acc = (acc << 4) | 32'(v);
        end
        v = hex_val(char_at(ndig + 1));
        if (v < 0 || v > int'(slcan_pkg::MAX_DLC)) return 1'b0;
        if (line_len < base + 2 * v) return 1'b0;
        for (int i = 0; i < v; i++) begin
            hi = hex_val(char_at(base + 2 * i));
            lo = hex_val(char_at(base + 2 * i + 1));
            if (hi < 0 || lo < 0) return 1'b0;
            data |= 64'(hi * 16 + lo) << (8 * i);
        end
        id  = acc[28:0];
        dlc = 4'(v);
        return 1'b1;
    endfunction

    // Advances the line model by one accepted character; returns 1 when a reply is due.
    function automatic bit predict_reply(input logic [7:0] ch, input bit link,
                                         output t_reply r);
        bit          ext;
        logic [28:0] id;
        logic [3:0]  dlc;
        logic [63:0] data;
        r = '0;
        if (ch != slcan_pkg::CH_CR && ch != slcan_pkg::CH_LF) begin
            if (line_len < LINE_CHARS) begin
                line_buf[line_len] = ch;
                line_len++;
            end
            return 1'b0;
        end
        if (line_len == 0) return 1'b0;
        r.kind = slcan_pkg::REPLY_BELL;
        case (char_at(0))
            slcan_pkg::CH_OPEN: begin
                if (chan_open || link) begin
                    chan_open = 1'b1;
                    r.kind = slcan_pkg::REPLY_OK;
                end
            end
            slcan_pkg::CH_CLOSE: begin
                chan_open = 1'b0;
                r.kind = slcan_pkg::REPLY_OK;
            end
            slcan_pkg::CH_SPEED: r.kind = slcan_pkg::REPLY_OK;
            slcan_pkg::CH_VER:   r.kind = slcan_pkg::REPLY_VERSION;
            slcan_pkg::CH_SER:   r.kind = slcan_pkg::REPLY_SERIAL;
            slcan_pkg::CH_STD, slcan_pkg::CH_EXT: begin
                ext = (char_at(0) == slcan_pkg::CH_EXT);
                if (decode_frame(ext, id, dlc, data)) begin
                    r.tx_valid = 1'b1;
                    r.tx_ext   = ext;
                    r.ident    = id;
                    r.dlc      = dlc;
                    r.payload  = data;
                    if (link) begin
                        r.kind = ext ? slcan_pkg::REPLY_ACK_EXT : slcan_pkg::REPLY_ACK_STD;
                    end
                end
            end
            default: ;
        endcase
        line_len  = 0;
        r.is_open = chan_open;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Each reply beat is compared with the oldest prediction still waiting.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: reply beat with none expected, expected nothing, actual kind %0d",
                         $time, o_reply_kind);
                fail_count++;
            end else begin
                oldest_reply = expected_replies.pop_front();
                check_field("reply_kind", 64'(oldest_reply.kind), 64'(o_reply_kind));
                check_field("channel_is_open", 64'(oldest_reply.is_open),
                            64'(o_channel_is_open));
                check_field("tx_valid", 64'(oldest_reply.tx_valid), 64'(o_tx_valid));
                check_field("tx_extended", 64'(oldest_reply.tx_ext), 64'(o_tx_extended));
                check_field("tx_ident", 64'(oldest_reply.ident), 64'(o_tx_ident));
                check_field("tx_length", 64'(oldest_reply.dlc), 64'(o_tx_length));
                check_field("tx_payload", oldest_reply.payload, o_tx_payload);
            end
        end
    end

    // The reply side switches between stall styles, including spells with no stall.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 256 == 0) stall_style <= $urandom_range(0, 3);
        case (stall_style)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 9) < 4);
            2:       i_out_stall <= (stall_phase % 8 < 3);
            default: i_out_stall <= ($urandom_range(0, 23) == 0) ? ~i_out_stall : i_out_stall;
        endcase
    end

    task automatic send_char(input logic [7:0] ch, input bit link);
        t_reply r;
        if (burst_left == 0) begin
            if (!sender_eager) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_rx_byte  <= ch;
        i_link_ok  <= link;
        do @(posedge i_clk); while (o_in_stall);
        sent_count++;
        if (predict_reply(ch, link, r)) expected_replies.push_back(r);
    endtask

    task automatic send_text(input string s, input bit link, input bit use_lf = 1'b0);
        for (int i = 0; i < s.len(); i++) send_char(s[i], 1'($urandom_range(0, 1)));
        send_char(use_lf ? slcan_pkg::CH_LF : slcan_pkg::CH_CR, link);
    endtask

    task automatic send_line(input bit link);
        foreach (line_chars[i]) send_char(line_chars[i], 1'($urandom_range(0, 1)));
        send_char($urandom_range(0, 1) ? slcan_pkg::CH_CR : slcan_pkg::CH_LF, link);
        if ($urandom_range(0, 9) == 0) send_char(slcan_pkg::CH_CR, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'(int'("0") + v);
        return 8'(($urandom_range(0, 1) ? int'("A") : int'("a")) + v - 10);
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(0, 255));
        while (ch == slcan_pkg::CH_CR || ch == slcan_pkg::CH_LF);
        return ch;
    endfunction

    function automatic void build_frame(input bit ext, input int dlc);
        line_chars.delete();
        line_chars.push_back(ext ? slcan_pkg::CH_EXT : slcan_pkg::CH_STD);
        repeat (ext ? 8 : 3) line_chars.push_back(hex_char($urandom_range(0, 15)));
        line_chars.push_back(hex_char(dlc));
        repeat (2 * dlc) line_chars.push_back(hex_char($urandom_range(0, 15)));
    endfunction

    function automatic void build_random_line();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        line_chars.delete();
        if (pick < 45) begin
            build_frame(1'($urandom_range(0, 1)), $urandom_range(0, 8));
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 6)) line_chars.push_back(noise_char());
        end else if (pick < 60) begin
            build_frame(1'($urandom_range(0, 1)), $urandom_range(0, 8));
            case ($urandom_range(0, 2))
                0: line_chars[$urandom_range(1, line_chars.size() - 1)] = noise_char();
                1: begin
                    n = $urandom_range(1, line_chars.size() - 1);
                    while (line_chars.size() > n) void'(line_chars.pop_back());
                end
                default: line_chars[line_chars[0] == slcan_pkg::CH_EXT ? 9 : 4] =
                    hex_char($urandom_range(9, 15));
            endcase
        end else if (pick < 70) begin
            line_chars.push_back(slcan_pkg::CH_OPEN);
        end else if (pick < 74) begin
            line_chars.push_back(slcan_pkg::CH_CLOSE);
        end else if (pick < 78) begin
            line_chars.push_back(slcan_pkg::CH_SPEED);
            line_chars.push_back(hex_char($urandom_range(0, 8)));
        end else if (pick < 82) begin
            line_chars.push_back(slcan_pkg::CH_VER);
        end else if (pick < 86) begin
            line_chars.push_back(slcan_pkg::CH_SER);
        end else if (pick < 94) begin
            repeat ($urandom_range(1, 12)) line_chars.push_back(noise_char());
        end else begin
            // Past the store limit, so the tail of the line is dropped.
            if ($urandom_range(0, 1)) build_frame(1'b1, 8);
            else line_chars.push_back(noise_char());
            repeat ($urandom_range(LINE_CHARS, LINE_CHARS + 12)) begin
                if (line_chars.size() < LINE_CHARS + 12)
                    line_chars.push_back(noise_char());
            end
        end
    endfunction

    task automatic test_simple_commands();
        sender_eager = 1'b1;
        send_char(slcan_pkg::CH_CR, 1'b1);
        send_char(slcan_pkg::CH_LF, 1'b0);
        send_text("V", 1'b1);
        send_text("N", 1'b0, 1'b1);
        send_text("S6", 1'b1);
        send_text("x1", 1'b1);
        send_text("t1230", 1'b1);
        send_text("O", 1'b0);
        send_text("O", 1'b1);
        send_text("O", 1'b0);
    endtask

    task automatic test_frames();
        sender_eager = 1'b0;
        send_text("t0000", 1'b1);
        send_text("TFFFFFFFF8FFFFFFFFFFFFFFFF", 1'b1);
        send_text("t7Ff80123456789aBcDeF", 1'b0, 1'b1);
        send_text("T123456789", 1'b1);
        send_text("t12G1AB", 1'b1);
        send_text("t@:/\140g", 1'b1);
        send_text("t12", 1'b1);
        send_text("t1232AB", 1'b1);
        send_text("t1231ABzz", 1'b1, 1'b1);
    endtask

    task automatic test_line_limit();
        send_text("T1abcdef880011223344556677EXTRA-TAIL-DROPPED", 1'b1);
        send_text("Vxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxx", 1'b1);
        send_text("q123456789012345678901234567890", 1'b0);
    endtask

    task automatic test_close();
        send_text("C", 1'b0);
        send_text("t1230", 1'b1);
        send_text("C", 1'b1);
        send_text("O", 1'b1);
    endtask

    task automatic test_random_traffic();
        int lines;
        lines = 0;
        while (sent_count < TOTAL_ITEMS) begin
            if ($urandom_range(0, 7) == 0) sender_eager = !sender_eager;
            build_random_line();
            send_line($urandom_range(0, 4) != 0);
            lines++;
            // Hold the host side back once until every reply has drained.
            if (lines == 20) wait_idle();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_simple_commands();
        wait_idle();
        test_frames();
        wait_idle();
        test_line_limit();
        wait_idle();
        test_close();
        wait_idle();
        test_random_traffic();
        wait_idle();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
design/slcan_pkg.sv
design/slcan_ctrl.sv
design/slcan_dp.sv
design/slcan_command_parser_core.sv
dv/slcan_command_parser_core_tb.sv
